/* design/rllt_pkg.sv */
package rllt_pkg;

	localparam int MAX_RUNS   = 256;
	localparam int COUNT_BITS = 16;

	localparam int RUN_IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int RUN_CNT_W = $clog2(MAX_RUNS + 1);

	localparam int KIND_W   = 2;
	localparam int LINE_W   = 16;
	localparam int INDEX_W  = 16;
	localparam int STATUS_W = 2;
	localparam int RUNS_W   = 9;
	localparam int BYTES_W  = 16;
	localparam int CMP_W    = (COUNT_BITS > INDEX_W) ? COUNT_BITS : INDEX_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNCOVERED = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPEND,
		S_WALK,
		S_REPORT
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [LINE_W-1:0]  line_number;
		logic [INDEX_W-1:0] byte_index;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LINE_W-1:0]   found_line;
		logic [RUNS_W-1:0]   runs_used;
		logic [BYTES_W-1:0]  bytes_recorded;
	} result_t;

	typedef struct packed {
		logic [LINE_W-1:0]     line;
		logic [COUNT_BITS-1:0] len;
	} run_entry_t;

	typedef struct packed {
		logic                 we;
		logic [RUN_IDX_W-1:0] waddr;
		run_entry_t           wdata;
		logic [RUN_IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

/* design/run_length_line_table.sv */
// Channel  Direction  Handshake           Word
// -------  ---------  ------------------  ------------------------------------
// command  in         start && !busy      cmd    : kind, line_number, byte_index
// result   out        done (one cycle)    result : status, found_line,
//                                                  runs_used, bytes_recorded
//
// Append, clear and the unused kind pass through one work state, S_APPEND or
// S_REPORT, before the result strobes. A lookup walks from run 0 to the run
// that holds the byte, or to the last run when none does (an empty table goes
// to S_REPORT): one shared add/compare unit walks the runs one per cycle through
// the single registered read port of the run store. Reset clears the sequencer
// and the run and byte counters; the run store itself is not cleared. The
// receiver cannot stall: done is high for exactly one cycle per accepted word.
module run_length_line_table
	import rllt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	state_t state_q, state_d;

	cmd_t                  cmd_q;
	logic [RUN_CNT_W-1:0]  run_total_q, run_total_d;
	logic [COUNT_BITS-1:0] byte_total_q, byte_total_d;
	logic [LINE_W-1:0]     last_line_q, last_line_d;
	logic [COUNT_BITS-1:0] last_len_q, last_len_d;
	logic [RUN_IDX_W-1:0]  walk_idx_q, walk_idx_d;
	logic [COUNT_BITS-1:0] sum_q, sum_d;
	logic                  done_q, done_d;
	result_t               result_q, result_d;

	mem_req_t   mem_req;
	run_entry_t rd_entry;

	logic [COUNT_BITS-1:0] alu_a, alu_b, alu_sum;
	logic                  alu_hit;

	logic accept;
	logic same_line;
	logic last_run;

	rllt_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rd_entry)
	);

	rllt_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.idx (cmd_q.byte_index),
		.sum (alu_sum),
		.hit (alu_hit)
	);

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign same_line = (run_total_q != '0) && (last_line_q == cmd_q.line_number);
	assign last_run  = (RUN_CNT_W'(walk_idx_q) + RUN_CNT_W'(1)) == run_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			run_total_q  <= '0;
			byte_total_q <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			run_total_q  <= run_total_d;
			byte_total_q <= byte_total_d;
			done_q       <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		last_line_q <= last_line_d;
		last_len_q  <= last_len_d;
		walk_idx_q  <= walk_idx_d;
		sum_q       <= sum_d;
		result_q    <= result_d;
	end

	always_comb begin
		state_d      = state_q;
		run_total_d  = run_total_q;
		byte_total_d = byte_total_q;
		last_line_d  = last_line_q;
		last_len_d   = last_len_q;
		walk_idx_d   = walk_idx_q;
		sum_d        = sum_q;
		done_d       = 1'b0;
		result_d     = result_q;

		mem_req       = '0;
		mem_req.raddr = '0;

		alu_a = sum_q;
		alu_b = rd_entry.len;

		case (state_q)
			S_IDLE: begin
				// read address sits at run 0, so a lookup finds it ready next cycle
				walk_idx_d = '0;
				sum_d      = '0;
				if (accept) begin
					if (cmd.kind == KIND_APPEND) begin
						state_d = S_APPEND;
					end else if (cmd.kind == KIND_LOOKUP && run_total_q != '0) begin
						state_d = S_WALK;
					end else begin
						state_d = S_REPORT;
					end
				end
			end

			S_APPEND: begin
				// lengthen the newest run, or open a new one
				alu_a = last_len_q;
				alu_b = COUNT_BITS'(1);
				result_d.found_line = '0;
				if (byte_total_q == COUNT_MAX
						|| (!same_line && run_total_q == RUN_CNT_W'(MAX_RUNS))) begin
					result_d.status = STATUS_FULL;
				end else begin
					result_d.status   = STATUS_OK;
					mem_req.we        = 1'b1;
					byte_total_d      = byte_total_q + COUNT_BITS'(1);
					if (same_line) begin
						mem_req.waddr      = RUN_IDX_W'(run_total_q - RUN_CNT_W'(1));
						mem_req.wdata.line = last_line_q;
						mem_req.wdata.len  = alu_sum;
						last_len_d         = alu_sum;
					end else begin
						mem_req.waddr      = RUN_IDX_W'(run_total_q);
						mem_req.wdata.line = cmd_q.line_number;
						mem_req.wdata.len  = COUNT_BITS'(1);
						last_line_d        = cmd_q.line_number;
						last_len_d         = COUNT_BITS'(1);
						run_total_d        = run_total_q + RUN_CNT_W'(1);
					end
				end
				result_d.runs_used      = RUNS_W'(run_total_d);
				result_d.bytes_recorded = BYTES_W'(byte_total_d);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			S_WALK: begin
				// rd_entry holds run walk_idx_q; fetch the next one meanwhile
				sum_d         = alu_sum;
				walk_idx_d    = walk_idx_q + RUN_IDX_W'(1);
				mem_req.raddr = walk_idx_q + RUN_IDX_W'(1);
				result_d.runs_used      = RUNS_W'(run_total_q);
				result_d.bytes_recorded = BYTES_W'(byte_total_q);
				if (alu_hit) begin
					result_d.status     = STATUS_OK;
					result_d.found_line = rd_entry.line;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (last_run) begin
					result_d.status     = STATUS_UNCOVERED;
					result_d.found_line = '0;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end

			S_REPORT: begin
				// clear, lookup on an empty table, or the unused kind
				result_d.found_line = '0;
				if (cmd_q.kind == KIND_CLEAR) begin
					run_total_d     = '0;
					byte_total_d    = '0;
					result_d.status = STATUS_OK;
				end else if (cmd_q.kind == KIND_LOOKUP) begin
					result_d.status = STATUS_UNCOVERED;
				end else begin
					result_d.status = STATUS_OK;
				end
				result_d.runs_used      = RUNS_W'(run_total_d);
				result_d.bytes_recorded = BYTES_W'(byte_total_d);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	// a result word only follows an accepted command
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in flight");

	// the walk never runs past the stored runs
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (RUN_CNT_W'(walk_idx_q) < run_total_q))
		else $error("lookup walk beyond stored runs");

	// the run count never exceeds the table size
	a_runs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		run_total_q <= RUN_CNT_W'(MAX_RUNS))
		else $error("run count beyond table size");

	// a word that is not a lookup never reports a line
	a_line_only_on_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cmd_q.kind) != KIND_LOOKUP) |-> (result.found_line == '0))
		else $error("found line on a non-lookup word");
`endif

endmodule

/* design/rllt_store.sv */
module rllt_store
	import rllt_pkg::*;
(
	input  logic       clk,
	input  mem_req_t   req,
	output run_entry_t rdata
);

	run_entry_t mem [MAX_RUNS];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

/* design/rllt_alu.sv */
module rllt_alu
	import rllt_pkg::*;
(
	input  logic [COUNT_BITS-1:0] a,
	input  logic [COUNT_BITS-1:0] b,
	input  logic [INDEX_W-1:0]    idx,
	output logic [COUNT_BITS-1:0] sum,
	output logic                  hit
);

	// add, then check whether the index falls below the running sum
	assign sum = a + b;
	assign hit = CMP_W'(idx) < CMP_W'(sum);

endmodule
